// ----- rtl/ipe_pkg.sv -----
package ipe_pkg;

  localparam int TBL_AW     = 5;
  localparam int TBL_DEPTH  = 1 << TBL_AW;
  localparam int WORD_W     = 16;
  localparam int BYTE_W     = 8;
  localparam int BL_W       = $clog2(BYTE_W + 1);
  localparam int PAIR_W     = 8;
  localparam int SB_W       = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam int MAX_SYMBOL_BITS_DEF = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_SYMBOL_BITS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAIR_COUNT  = 2'd1;

  // table read request: symbol selects the word pair {sym,0} / {sym,1}
  typedef struct packed {
    logic              en;
    logic [TBL_AW-2:0] sym;
  } rd_req_t;

  // output register control from the unpacker
  typedef struct packed {
    logic load;
    logic last;
  } out_ctl_t;

endpackage

// ----- rtl/ipe_if.sv -----
interface ipe_in_if;
  import ipe_pkg::*;

  logic              valid;
  logic              ready;
  logic              mode;
  logic [TBL_AW-1:0] table_index;
  logic [WORD_W-1:0] table_value;
  logic [BYTE_W-1:0] code_byte;

  modport source (output valid, mode, table_index, table_value, code_byte, input ready);
  modport sink (input valid, mode, table_index, table_value, code_byte, output ready);
endinterface

interface ipe_out_if;
  import ipe_pkg::*;

  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] mark_time;
  logic [WORD_W-1:0] space_time;
  logic              last;

  modport source (output valid, mark_time, space_time, last, input ready);
  modport sink (input valid, mark_time, space_time, last, output ready);
endinterface

// ----- rtl/ir_pulse_pair_expander.sv -----
// IR pulse pair expander. A request with mode 0 writes one 16-bit timing word into
// the 32-word table. A request with mode 1 delivers one code byte, which is
// shifted out one bit per clock while in the shift state, MSB first, into a
// symbol of symbol_bits bits that may span bytes; each finished symbol then
// waits in the read state for the registered table read of its word pair, and
// the pair (times ten, 16-bit wrap) goes to the output register. After it is
// taken, a code byte therefore holds in_ch.ready low for its eight shifts plus
// one read per finished symbol, fewer when the code ends inside it. Any time the
// output is held off by out_ch.ready adds to that, since the single bit shifter
// and the one output register serve one byte at a time. A byte arriving with
// pair_count 0 is dropped. The pair that completes pair_count carries last, the
// rest of that byte is discarded and the next byte starts a new code. The table
// has no reset: entries must be written before a code uses them.
module ir_pulse_pair_expander #(
  parameter int MAX_SYMBOL_BITS = ipe_pkg::MAX_SYMBOL_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  ipe_in_if.sink                         in_ch,
  ipe_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [ipe_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ipe_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import ipe_pkg::*;

  logic [SB_W-1:0]   symbol_bits_r;
  logic [PAIR_W-1:0] pair_count_r;

  logic              out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0] out_mark_r;
  logic [WORD_W-1:0] out_space_r;
  logic              out_last_r;

  logic              in_acc;
  logic              idle;
  logic              slot_free;
  rd_req_t           req;
  out_ctl_t          ctl;
  logic [WORD_W-1:0] mark_scaled;
  logic [WORD_W-1:0] space_scaled;

  assign in_ch.ready = idle;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign slot_free   = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      symbol_bits_r <= SB_W'(1);
      pair_count_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SYMBOL_BITS: symbol_bits_r <= cfg_wdata[SB_W-1:0];
        CFG_PAIR_COUNT:  pair_count_r  <= cfg_wdata[PAIR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  ipe_table u_table (
    .clk          (clk),
    .wr_en        (in_acc && !in_ch.mode),
    .wr_addr      (in_ch.table_index),
    .wr_data      (in_ch.table_value),
    .req          (req),
    .mark_scaled  (mark_scaled),
    .space_scaled (space_scaled)
  );

  ipe_unpack #(
    .MAX_SYMBOL_BITS (MAX_SYMBOL_BITS)
  ) u_unpack (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (in_acc && in_ch.mode),
    .code_byte   (in_ch.code_byte),
    .symbol_bits (symbol_bits_r),
    .pair_count  (pair_count_r),
    .slot_free   (slot_free),
    .idle        (idle),
    .req         (req),
    .ctl         (ctl)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctl.load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      out_mark_r  <= mark_scaled;
      out_space_r <= space_scaled;
      out_last_r  <= ctl.last;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.mark_time  = out_mark_r;
  assign out_ch.space_time = out_space_r;
  assign out_ch.last       = out_last_r;

endmodule

// ----- rtl/ipe_table.sv -----
module ipe_table (
  input  logic                    clk,
  input  logic                    wr_en,
  input  logic [ipe_pkg::TBL_AW-1:0] wr_addr,
  input  logic [ipe_pkg::WORD_W-1:0] wr_data,
  input  ipe_pkg::rd_req_t        req,
  output logic [ipe_pkg::WORD_W-1:0] mark_scaled,
  output logic [ipe_pkg::WORD_W-1:0] space_scaled
);
  import ipe_pkg::*;

  logic [WORD_W-1:0] mem [TBL_DEPTH];
  logic [WORD_W-1:0] rd0_r;
  logic [WORD_W-1:0] rd1_r;

  // x10 as x8 + x2, wrapping to the word width
  function automatic logic [WORD_W-1:0] times_ten(input logic [WORD_W-1:0] w);
    return (w << 3) + (w << 1);
  endfunction

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (req.en) begin
      rd0_r <= mem[{req.sym, 1'b0}];
      rd1_r <= mem[{req.sym, 1'b1}];
    end
  end

  assign mark_scaled  = times_ten(rd0_r);
  assign space_scaled = times_ten(rd1_r);

endmodule

// ----- rtl/ipe_unpack.sv -----
module ipe_unpack #(
  parameter int MAX_SYMBOL_BITS = ipe_pkg::MAX_SYMBOL_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [ipe_pkg::BYTE_W-1:0] code_byte,
  input  logic [ipe_pkg::SB_W-1:0]   symbol_bits,
  input  logic [ipe_pkg::PAIR_W-1:0] pair_count,
  input  logic                       slot_free,
  output logic                       idle,
  output ipe_pkg::rd_req_t           req,
  output ipe_pkg::out_ctl_t          ctl
);
  import ipe_pkg::*;

  localparam int SYM_W = MAX_SYMBOL_BITS;
  localparam int PB_W  = $clog2(MAX_SYMBOL_BITS + 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SHIFT = 2'd1;
  localparam logic [1:0] ST_READ  = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic [BYTE_W-1:0] byte_r, byte_nxt;
  logic [BL_W-1:0]   bl_r, bl_nxt;
  logic [SYM_W-1:0]  ps_r, ps_nxt;
  logic [PB_W-1:0]   pb_r, pb_nxt;
  logic [PAIR_W-1:0] pd_r, pd_nxt;
  logic              fin_r, fin_nxt;

  logic [PB_W-1:0]   w_use;
  logic [SYM_W-1:0]  ps_shift;
  logic [PB_W-1:0]   pb_inc;
  logic [PAIR_W:0]   done_cnt;
  logic              fin_now;

  // symbol width clamped to 1..MAX_SYMBOL_BITS
  always_comb begin
    if (symbol_bits == '0) begin
      w_use = PB_W'(1);
    end else if (int'(symbol_bits) > MAX_SYMBOL_BITS) begin
      w_use = PB_W'(MAX_SYMBOL_BITS);
    end else begin
      w_use = PB_W'(symbol_bits);
    end
  end

  assign ps_shift = SYM_W'({ps_r, byte_r[BYTE_W-1]});
  assign pb_inc   = pb_r + 1'b1;
  assign done_cnt = {1'b0, pd_r} + 1'b1;
  assign fin_now  = done_cnt >= {1'b0, pair_count};

  always_comb begin
    state_nxt = state_r;
    byte_nxt  = byte_r;
    bl_nxt    = bl_r;
    ps_nxt    = ps_r;
    pb_nxt    = pb_r;
    pd_nxt    = pd_r;
    fin_nxt   = fin_r;
    req       = '0;
    ctl       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (pair_count == '0) begin
            // empty code: drop the byte, keep the decoder cleared
            ps_nxt = '0;
            pb_nxt = '0;
            pd_nxt = '0;
          end else begin
            byte_nxt  = code_byte;
            bl_nxt    = BL_W'(BYTE_W);
            state_nxt = ST_SHIFT;
          end
        end
      end
      ST_SHIFT: begin
        byte_nxt = byte_r << 1;
        bl_nxt   = bl_r - 1'b1;
        if (pb_inc >= w_use) begin
          req.en    = 1'b1;
          req.sym   = (TBL_AW-1)'(ps_shift);
          ps_nxt    = '0;
          pb_nxt    = '0;
          fin_nxt   = fin_now;
          if (!fin_now) begin
            pd_nxt = pd_r + 1'b1;
          end
          state_nxt = ST_READ;
        end else begin
          ps_nxt = ps_shift;
          pb_nxt = pb_inc;
          if (bl_r == BL_W'(1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_READ: begin
        if (slot_free) begin
          ctl.load = 1'b1;
          ctl.last = fin_r;
          if (fin_r) begin
            // end of code: rest of the byte is dropped
            pd_nxt    = '0;
            bl_nxt    = '0;
            state_nxt = ST_IDLE;
          end else if (bl_r == '0) begin
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_SHIFT;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      bl_r    <= '0;
      ps_r    <= '0;
      pb_r    <= '0;
      pd_r    <= '0;
      fin_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      bl_r    <= bl_nxt;
      ps_r    <= ps_nxt;
      pb_r    <= pb_nxt;
      pd_r    <= pd_nxt;
      fin_r   <= fin_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
  end

  assign idle = (state_r == ST_IDLE);

  a_req_then_read: assert property (@(posedge clk) disable iff (!rst_n)
    req.en |=> state_r == ST_READ)
    else $error("table read not followed by read state");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.load |-> slot_free && state_r == ST_READ)
    else $error("output loaded while slot busy");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.load && ctl.last |=> state_r == ST_IDLE && pd_r == '0 && pb_r == '0)
    else $error("decoder not cleared after last pair");

  a_shift_bits: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SHIFT |-> bl_r != '0)
    else $error("shifting with no bits left");

endmodule
